// File: rtl/core/cbhm_pkg.sv
// Package for the clock binding hash map core.
// Holds the transaction payload types and the status codes; no dependencies.

package cbhm_pkg;

	localparam int KEY_W    = 64;
	localparam int VALUE_W  = 64;
	localparam int STATUS_W = 3;
	localparam int BOUND_W  = 7;
	localparam int DROP_W   = 32;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_NEW     = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_UPDATED = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_DROPPED = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_IGNORED = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_HIT     = 3'd4;
	localparam logic [STATUS_W-1:0] STATUS_MISS    = 3'd5;

	// Operation codes.
	localparam logic OP_BIND   = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Request transaction.
	typedef struct packed {
		logic               operation;
		logic [KEY_W-1:0]   clock_key;
		logic [VALUE_W-1:0] client_value;
	} req_t;

	// Response transaction.
	typedef struct packed {
		logic [VALUE_W-1:0]  found_value;
		logic [STATUS_W-1:0] status;
		logic [BOUND_W-1:0]  bound_count;
		logic [DROP_W-1:0]   dropped_count;
	} rsp_t;

endpackage

// File: rtl/core/cbhm_slot_ram.sv
// Slot memory of the hash map: one write port and one registered read port.
// Depends on nothing but its parameters.

module cbhm_slot_ram #(
	parameter int DEPTH = 64,
	parameter int DATA_W = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/cbhm_home.sv
// Home slot unit: hashes a key and reduces the hash modulo the slot count.
// Uses cbhm_pkg for the key width; four remainder steps per cycle.

module cbhm_home import cbhm_pkg::*; #(
	parameter int SLOTS = 64,
	localparam int SW = $clog2(SLOTS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] key,
	output logic             done,
	output logic [SW-1:0]    home
);

	localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
	localparam int BITS_PER_STEP = 4;
	localparam int STEPS = KEY_W / BITS_PER_STEP;
	localparam int CW = $clog2(STEPS + 1);

	logic [KEY_W-1:0] h_q;
	logic [SW-1:0]    r_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic [SW-1:0]    r_next;

	// Four restoring remainder steps, most significant hash bits first.
	always_comb begin
		logic [SW:0] t;
		r_next = r_q;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			t = {r_next, h_q[KEY_W-1-i]};
			if (t >= (SW+1)'(SLOTS)) begin
				t = t - (SW+1)'(SLOTS);
			end
			r_next = t[SW-1:0];
		end
	end

	assign done = run_q && (POW2 || (cnt_q == CW'(STEPS)));
	assign home = POW2 ? h_q[SW-1:0] : r_q;

	// Sequencing of the reduction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			if (done) begin
				run_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// Hash word and partial remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= (key >> 4) ^ (key >> 13);
			r_q <= '0;
		end else if (run_q && !done) begin
			h_q <= h_q << BITS_PER_STEP;
			r_q <= r_next;
		end
	end

endmodule

// File: rtl/core/clock_binding_hash_map_core.sv
// Clock binding hash map: insert-only map with linear probing over SLOTS slots.
// After reset a clearing pass writes every slot to empty the key store; no request is taken then.
// Per request: the home slot is computed (low hash bits when SLOTS is a power of two, a modulo
// reduction otherwise), then a memory read and a key compare per probed slot, then the
// response register loads. Bind of a zero key or value and lookup of a zero key skip the walk.
// Requests are taken one at a time: the next one in the cycle after the response register loads.

module clock_binding_hash_map_core import cbhm_pkg::*; #(
	parameter int SLOTS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int SW = $clog2(SLOTS);
	localparam int OW = $clog2(SLOTS + 1);
	localparam int MEM_W = KEY_W + VALUE_W;

	// Sequencer states.
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_HASH  = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_CHECK = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]          state_q;
	logic                op_q;
	logic [KEY_W-1:0]    key_q;
	logic [VALUE_W-1:0]  val_q;
	logic [SW-1:0]       slot_q;
	logic [SW-1:0]       n_q;
	logic [STATUS_W-1:0] status_q;
	logic [VALUE_W-1:0]  found_q;
	logic [OW-1:0]       occ_q;
	logic [DROP_W-1:0]   drop_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic                accept;
	logic                home_done;
	logic [SW-1:0]       home;
	logic                mem_we;
	logic [MEM_W-1:0]    mem_wdata;
	logic [MEM_W-1:0]    mem_rdata;
	logic [KEY_W-1:0]    slot_key;
	logic [VALUE_W-1:0]  slot_val;
	logic                key_match;
	logic                slot_empty;
	logic                last_probe;
	logic [SW-1:0]       slot_next;
	logic                rsp_load;
	logic [31:0]         occ_ext;

	assign req_stall = (state_q != ST_IDLE);
	assign accept = req_valid && !req_stall;

	// Home slot computation, started on every accepted request.
	cbhm_home #(
		.SLOTS(SLOTS)
	) u_home (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.key   (req.clock_key),
		.done  (home_done),
		.home  (home)
	);

	// Key and value store, one word per slot.
	cbhm_slot_ram #(
		.DEPTH (SLOTS),
		.DATA_W(MEM_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(slot_q),
		.wdata(mem_wdata),
		.raddr(slot_q),
		.rdata(mem_rdata)
	);

	assign slot_key = mem_rdata[MEM_W-1:VALUE_W];
	assign slot_val = mem_rdata[VALUE_W-1:0];

	// Shared probe compare.
	assign key_match = (slot_key == key_q);
	assign slot_empty = (slot_key == '0);
	assign last_probe = (n_q == SW'(SLOTS - 1));
	assign slot_next = (slot_q == SW'(SLOTS - 1)) ? '0 : slot_q + SW'(1);

	// Memory writes: clearing pass, or a bind that claims or updates a slot.
	always_comb begin
		mem_we = 1'b0;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_CHECK: begin
				if (op_q == OP_BIND && (key_match || slot_empty)) begin
					mem_we = 1'b1;
					mem_wdata = {key_q, val_q};
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign rsp_load = (state_q == ST_OUT) && (!rsp_valid_q || !rsp_stall);

	// Control sequencer and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			slot_q <= '0;
			occ_q <= '0;
			drop_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (slot_q == SW'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
					slot_q <= slot_next;
				end
				ST_IDLE: begin
					if (accept) begin
						if (req.operation == OP_BIND &&
						    (req.clock_key == '0 || req.client_value == '0)) begin
							state_q <= ST_OUT;
						end else if (req.operation == OP_LOOKUP && req.clock_key == '0) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_HASH;
						end
					end
				end
				ST_HASH: begin
					if (home_done) begin
						slot_q <= home;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (key_match || slot_empty || last_probe) begin
						state_q <= ST_OUT;
						if (op_q == OP_BIND && !key_match && slot_empty) begin
							occ_q <= occ_q + OW'(1);
						end else if (op_q == OP_BIND && !key_match && !slot_empty &&
						             drop_q != '1) begin
							drop_q <= drop_q + DROP_W'(1);
						end
					end else begin
						slot_q <= slot_next;
						state_q <= ST_READ;
					end
				end
				ST_OUT: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture and per-request outcome.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req.operation;
			key_q <= req.clock_key;
			val_q <= req.client_value;
			found_q <= '0;
			if (req.operation == OP_BIND) begin
				status_q <= STATUS_IGNORED;
			end else begin
				status_q <= STATUS_MISS;
			end
		end
		if (state_q == ST_HASH && home_done) begin
			n_q <= '0;
		end else if (state_q == ST_CHECK) begin
			n_q <= n_q + SW'(1);
			if (op_q == OP_BIND) begin
				if (key_match) begin
					status_q <= STATUS_UPDATED;
				end else if (slot_empty) begin
					status_q <= STATUS_NEW;
				end else if (last_probe) begin
					status_q <= STATUS_DROPPED;
				end
			end else begin
				if (key_match) begin
					status_q <= STATUS_HIT;
					found_q <= slot_val;
				end else if (slot_empty || last_probe) begin
					status_q <= STATUS_MISS;
				end
			end
		end
	end

	// Response register.
	assign occ_ext = 32'(occ_q);

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.found_value <= found_q;
			rsp_q.status <= status_q;
			rsp_q.bound_count <= occ_ext[BOUND_W-1:0];
			rsp_q.dropped_count <= drop_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef SYNTHESIS
	// The occupied count can never pass the number of slots.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(SLOTS))
		else $error("occupied count exceeds slot count");

	// A lookup never writes the slot memory.
	a_lookup_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && mem_we) |-> (op_q == OP_BIND))
		else $error("slot write during lookup");

	// The drop counter never goes backward.
	a_drop_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (drop_q >= $past(drop_q)))
		else $error("drop counter decreased");

	// A request that needs a walk starts hashing in the next cycle.
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.clock_key != '0 &&
		 (req.operation == OP_LOOKUP || req.client_value != '0)) |=> (state_q == ST_HASH))
		else $error("walk did not start");
`endif

endmodule
